/* rtl/core/sfir_pkg.sv */
package sfir_pkg;

  // Kernel and frame geometry
  localparam int TAPS       = 5;
  localparam int CENTER     = TAPS / 2;
  localparam int LINES      = TAPS - 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Field widths
  localparam int PIX_W        = 16;
  localparam int COEF_W       = 17;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int NUM_COEF     = 5;
  localparam int COEF_IDX_W   = $clog2(NUM_COEF);

  // Line slots are picked by the low row bits, so LINES is a power of two
  localparam int SLOT_W    = $clog2(LINES);
  localparam int STEP_W    = $clog2(CENTER + 1);
  localparam int WIN_IDX_W = $clog2(TAPS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_3       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_4       = 3'd6;

  typedef logic signed [PIX_W-1:0]  pix_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [TAPS-1:0][PIX_W-1:0]      window_t;
  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_arr_t;

  // One queued pixel: the window after it was shifted in, plus its position
  typedef struct packed {
    window_t          win;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             filt;
    logic             row_end;
    logic             frame_end;
    logic             emit;
  } entry_t;

endpackage

/* rtl/core/sfir_pixel_if.sv */
interface sfir_pixel_if;
  import sfir_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

/* rtl/core/sfir_result_if.sv */
interface sfir_result_if;
  import sfir_pkg::*;

  logic             valid;
  logic             ready;
  pix_t             value;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic             last_of_run;
  logic             end_of_frame;

  modport source (output valid, output value, output column, output row,
                  output last_of_run, output end_of_frame, input ready);
  modport sink (input valid, input value, input column, input row,
                input last_of_run, input end_of_frame, output ready);
endinterface

/* rtl/core/sfir_ram.sv */
module sfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/core/sfir_front.sv */
module sfir_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [sfir_pkg::WIDTH_REG_W-1:0]  image_width,
  input  logic [sfir_pkg::HEIGHT_REG_W-1:0] image_height,
  sfir_pixel_if.sink                        pixels,
  input  logic                              queue_full,
  output logic                              push,
  output sfir_pkg::entry_t                  entry
);
  import sfir_pkg::*;

  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [COL_W-1:0]        col, col_last, x;
  logic [ROW_W-1:0]        row, row_last, y;
  window_t                 win, win_next;
  logic                    accept, row_end, frame_end;

  // Clamp the frame size to what the line store and kernel allow
  always_comb begin
    if (image_width < WIDTH_REG_W'(TAPS)) begin
      w_eff = WIDTH_REG_W'(TAPS);
    end else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height < HEIGHT_REG_W'(TAPS)) begin
      h_eff = HEIGHT_REG_W'(TAPS);
    end else if (image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  assign col_last = COL_W'(w_eff - WIDTH_REG_W'(1));
  assign row_last = ROW_W'(h_eff - HEIGHT_REG_W'(1));

  // A position past a shrunk frame saturates to the last column or row
  assign x = (col > col_last) ? col_last : col;
  assign y = (row > row_last) ? row_last : row;

  assign row_end   = (x == col_last);
  assign frame_end = row_end && (y == row_last);

  assign pixels.ready = !queue_full;
  assign accept       = pixels.valid && pixels.ready;
  assign win_next     = {pixels.pixel, win[TAPS-1:1]};

  assign push            = accept && (x >= COL_W'(CENTER));
  assign entry.win       = win_next;
  assign entry.col       = x - COL_W'(CENTER);
  assign entry.row       = y;
  assign entry.filt      = (x >= COL_W'(2 * CENTER));
  assign entry.row_end   = row_end;
  assign entry.frame_end = frame_end;
  assign entry.emit      = (y >= ROW_W'(2 * CENTER));

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        row <= (y == row_last) ? '0 : y + ROW_W'(1);
      end else begin
        col <= x + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end
endmodule

/* rtl/core/sfir_queue.sv */
module sfir_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfir_pkg::entry_t wr_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output sfir_pkg::entry_t head
);
  import sfir_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end
endmodule

/* rtl/core/sfir_back.sv */
module sfir_back (
  input  logic                clk,
  input  logic                rst,
  input  sfir_pkg::coef_arr_t coef,
  input  logic                head_valid,
  input  sfir_pkg::entry_t    head,
  output logic                pop,
  sfir_result_if.source       results
);
  import sfir_pkg::*;

  localparam int PROD_W = PIX_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  localparam int FRAC   = 15;

  typedef logic [TAPS-1:0][PROD_W-1:0] prod_arr_t;

  function automatic logic signed [ACC_W-1:0] sum_taps(input prod_arr_t p);
    logic signed [ACC_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < TAPS; i++) begin
      acc = acc + ACC_W'($signed(p[i]));
    end
    return acc;
  endfunction

  // Round half up at the binary point, then saturate to the sample range
  function automatic pix_t round_sat(input logic signed [ACC_W-1:0] sum);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] q;
    pix_t                    r;
    rnd         = '0;
    rnd[FRAC-1] = 1'b1;
    q           = (sum + rnd) >>> FRAC;
    if (q[ACC_W-1:PIX_W-1] == '0 || q[ACC_W-1:PIX_W-1] == '1) begin
      r = q[PIX_W-1:0];
    end else if (q[ACC_W-1]) begin
      r = {1'b1, {(PIX_W - 1){1'b0}}};
    end else begin
      r = {1'b0, {(PIX_W - 1){1'b1}}};
    end
    return r;
  endfunction

  // Sequencer over the head entry
  logic [STEP_W-1:0]    step;
  logic                 adv, issue, last_step;
  logic [COL_W-1:0]     task_col;
  logic [WIN_IDX_W-1:0] raw_idx;

  // Pipeline registers
  logic                 v1, v2, v3, v4;
  logic [COL_W-1:0]     j1, j2, j3, j4;
  logic [ROW_W-1:0]     y1, y2, y3, y4;
  logic                 last1, last2, last3, last4;
  logic                 eof1, eof2, eof3, eof4;
  logic                 emit1, emit2, emit3, emit4;
  logic                 filt1, filt2;
  pix_t                 raw1, raw2;
  window_t              win1;
  prod_arr_t            hprod2, vprod4;
  pix_t                 ld2 [LINES];
  pix_t                 ld3 [LINES];
  pix_t                 h3;

  // Line store
  logic [LINES-1:0]     ram_we;
  logic [PIX_W-1:0]     ram_rd [LINES];

  // Output register
  logic                 out_valid;
  pix_t                 out_value;
  logic [COL_W-1:0]     out_col;
  logic [ROW_W-1:0]     out_row;
  logic                 out_last, out_eof;

  assign adv       = !out_valid || results.ready;
  assign issue     = adv && head_valid;
  assign last_step = !head.row_end || (step == STEP_W'(CENTER));
  assign pop       = issue && last_step;
  assign task_col  = head.col + COL_W'(step);
  assign raw_idx   = WIN_IDX_W'(CENTER) + WIN_IDX_W'(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (issue) begin
      step <= last_step ? '0 : step + STEP_W'(1);
    end
  end

  for (genvar k = 0; k < LINES; k++) begin : g_line
    assign ram_we[k] = adv && v3 && (y3[SLOT_W-1:0] == SLOT_W'(k));

    sfir_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (ram_we[k]),
      .waddr (j3),
      .wdata (h3),
      .re    (adv),
      .raddr (task_col),
      .rdata (ram_rd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= issue;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4 && emit4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Issue
      j1    <= task_col;
      y1    <= head.row;
      last1 <= last_step;
      eof1  <= last_step && head.frame_end;
      emit1 <= head.emit;
      filt1 <= head.filt && (step == '0);
      raw1  <= head.win[raw_idx];
      win1  <= head.win;

      // Horizontal products; line store rows lined up oldest first
      for (int i = 0; i < TAPS; i++) begin
        hprod2[i] <= $signed(win1[i]) * $signed(coef[i]);
      end
      for (int i = 0; i < LINES; i++) begin
        ld2[i] <= ram_rd[SLOT_W'(y1[SLOT_W-1:0] + SLOT_W'(i))];
      end
      j2    <= j1;
      y2    <= y1;
      last2 <= last1;
      eof2  <= eof1;
      emit2 <= emit1;
      filt2 <= filt1;
      raw2  <= raw1;

      // Horizontal result; border columns pass the raw sample
      h3    <= filt2 ? round_sat(sum_taps(hprod2)) : raw2;
      ld3   <= ld2;
      j3    <= j2;
      y3    <= y2;
      last3 <= last2;
      eof3  <= eof2;
      emit3 <= emit2;

      // Vertical products, current row last
      for (int i = 0; i < LINES; i++) begin
        vprod4[i] <= $signed(ld3[i]) * $signed(coef[i]);
      end
      vprod4[LINES] <= $signed(h3) * $signed(coef[TAPS-1]);
      j4    <= j3;
      y4    <= y3;
      last4 <= last3;
      eof4  <= eof3;
      emit4 <= emit3;

      // Output
      out_value <= round_sat(sum_taps(vprod4));
      out_col   <= j4;
      out_row   <= y4 - ROW_W'(CENTER);
      out_last  <= last4;
      out_eof   <= eof4;
    end
  end

  assign results.valid        = out_valid;
  assign results.value        = out_value;
  assign results.column       = out_col;
  assign results.row          = out_row;
  assign results.last_of_run  = out_last;
  assign results.end_of_frame = out_eof;

`ifndef NO_ASSERTIONS
  a_run_on_row_end : assert property (@(posedge clk) disable iff (rst)
    (step != '0) |-> (head_valid && head.row_end))
    else $error("run step active without a row-end entry at the head");

  a_no_rw_collision : assert property (@(posedge clk) disable iff (rst)
    (issue && v3) |-> (task_col != j3))
    else $error("line store read and write hit the same column");

  a_eof_is_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_eof) |-> out_last)
    else $error("frame end flagged on a result that does not close its run");

  a_pop_after_run : assert property (@(posedge clk) disable iff (rst)
    (issue && step == STEP_W'(CENTER)) |=> (step == '0))
    else $error("run did not retire after its last column");
`endif
endmodule

/* rtl/core/separable_fir_image_filter.sv */
// Separable 2-D FIR image filter. Pixels arrive in raster order on the
// pixels channel, one transaction per pixel, and filtered samples leave on
// the results channel tagged with their column and row. Each row is filtered
// horizontally with the TAPS-long kernel held in coef_0..coef_4 (signed
// Q2.15); the CENTER columns nearest each edge pass through unfiltered. The
// horizontal results go into TAPS-1 line RAMs of MAX_WIDTH words, and the
// same kernel is applied down each column; only rows at least CENTER rows
// from the top and bottom are produced. Both passes round half up and
// saturate to 16 bits. The block sustains one pixel per clock while the
// results channel is ready: the front end takes a pixel every cycle unless
// its 4-entry queue is full, and the back end retires one column per cycle
// unless the output is stalled. The last pixel of a row yields CENTER+1
// columns; the queue absorbs them while the first CENTER pixels of the next
// row produce no column. The line RAMs have no reset and need no clearing
// pass; the first 2*CENTER rows of a frame fill them before any result reads
// them. Write image_width, image_height and the taps only while no
// transaction is in flight; sizes are clamped to [TAPS, MAX_WIDTH] and
// [TAPS, 4096].
module separable_fir_image_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sfir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfir_pkg::CFG_DATA_W-1:0] cfg_data,
  sfir_pixel_if.sink                      pixels,
  sfir_result_if.source                   results
);
  import sfir_pkg::*;

  // Configuration registers
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  coef_arr_t               coef;

  // Front to queue to back
  logic   push, queue_full, pop, head_valid;
  entry_t wr_entry, head;

  // Decode register writes; unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(1024);
      image_height <= HEIGHT_REG_W'(1024);
      coef         <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index) inside
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[WIDTH_REG_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[HEIGHT_REG_W-1:0];
        end
        REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4: begin
          coef[COEF_IDX_W'(cfg_index - REG_COEF_0)] <= cfg_data[COEF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front: track position, hold the row window, classify each pixel
  sfir_front u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .pixels       (pixels),
    .queue_full   (queue_full),
    .push         (push),
    .entry        (wr_entry)
  );

  // Decouple the front from back-end stalls and row-end runs
  sfir_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (wr_entry),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: expand entries into columns, run both passes, own the line store
  sfir_back u_back (
    .clk        (clk),
    .rst        (rst),
    .coef       (coef),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .results    (results)
  );
endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import sfir_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 4;
  // Margin for the pixel-to-result pipeline plus up to four queued pixels
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 64;
  localparam int REPORT_LIMIT  = 10;
  localparam int RESET_HEIGHT  = 1024;
  // Widest row written early on, by the frame that fills every line slot
  localparam int STORE_COLS    = 12;
  // Rows of the hold-off frame: enough results after the first one to
  // back the block up into its input
  localparam int HOLD_ROWS     = 7;
  localparam int COEF_MAX      = 65535;
  localparam int COEF_MIN      = -65536;

  localparam pix_t PIX_HI = 16'sh7fff;
  localparam pix_t PIX_LO = 16'sh8000;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    pix_t             value;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last_of_run;
    logic             end_of_frame;
  } filt_sample_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sfir_pixel_if  pix_ch ();
  sfir_result_if res_ch ();

  separable_fir_image_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .results   (res_ch)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Filter state mirrored on the bench side: registers, line store, the
  // last TAPS pixels of the row, and the raster position of the next pixel.
  // ---------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  coef_t                   kernel [NUM_COEF];
  pix_t                    line_mem [LINES][MAX_WIDTH];
  pix_t                    recent_px [TAPS];
  int                      col_pos;
  int                      row_pos;

  pix_t         pixels_to_send [$];
  filt_sample_t samples_due [$];
  int           pixels_queued = 0;
  int           bad_samples = 0;

  int   sender_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_armed = 1'b0;
  logic hold_off = 1'b0;

  // Round half up at bit 15, then clip to 16 bits signed.
  function automatic pix_t round_clip(input logic signed [47:0] acc);
    logic signed [47:0] q;
    q = (acc + 48'sd16384) >>> 15;
    if (q > 48'sd32767) return PIX_HI;
    if (q < -48'sd32768) return PIX_LO;
    return q[PIX_W-1:0];
  endfunction

  // Vertical pass for one horizontally filtered sample of column j, row y.
  // Rows below 2*CENTER only fill the line store.
  function automatic bit column_pass(input pix_t hval, input int j, input int y,
                                     output filt_sample_t s);
    logic signed [47:0] acc;
    int i;
    bit produced;
    produced = 1'b0;
    s = '0;
    if (y >= 2 * CENTER) begin
      acc = '0;
      for (i = 0; i < LINES; i++) begin
        acc += line_mem[(y - 2 * CENTER + i) % LINES][j] * kernel[i];
      end
      acc += hval * kernel[TAPS-1];
      s.value  = round_clip(acc);
      s.column = COL_W'(j);
      s.row    = ROW_W'(y - CENTER);
      produced = 1'b1;
    end
    line_mem[y % LINES][j] = hval;
    return produced;
  endfunction

  // Full filter step for one accepted pixel; appends the samples it yields.
  task automatic filter_pixel(input pix_t px);
    int wd, ht, x, y, i, j, n;
    logic signed [47:0] acc;
    pix_t hval;
    filt_sample_t run [CENTER+1];
    wd = int'(width_reg);
    ht = int'(height_reg);
    if (wd < TAPS) wd = TAPS;
    if (wd > MAX_WIDTH) wd = MAX_WIDTH;
    if (ht < TAPS) ht = TAPS;
    if (ht > MAX_HEIGHT) ht = MAX_HEIGHT;
    // A size shrunk under the counters pins them to the last column/row
    if (col_pos >= wd) col_pos = wd - 1;
    if (row_pos >= ht) row_pos = ht - 1;
    x = col_pos;
    y = row_pos;
    for (i = 0; i < TAPS - 1; i++) begin
      recent_px[i] = recent_px[i+1];
    end
    recent_px[TAPS-1] = px;
    n = 0;
    if (x >= CENTER) begin
      if (x >= 2 * CENTER) begin
        acc = '0;
        for (i = 0; i < TAPS; i++) begin
          acc += recent_px[i] * kernel[i];
        end
        hval = round_clip(acc);
      end else begin
        // Left border column: pass through
        hval = recent_px[CENTER];
      end
      if (column_pass(hval, x - CENTER, y, run[n])) n++;
    end
    // Row end: flush the right border columns unfiltered
    if (x == wd - 1) begin
      for (j = wd - CENTER; j < wd; j++) begin
        if (column_pass(recent_px[TAPS-1-(wd-1-j)], j, y, run[n])) n++;
      end
    end
    if (n > 0) begin
      run[n-1].last_of_run = 1'b1;
      if (x == wd - 1 && y == ht - 1) run[n-1].end_of_frame = 1'b1;
    end
    for (i = 0; i < n; i++) begin
      samples_due.push_back(run[i]);
    end
    if (x == wd - 1) begin
      col_pos = 0;
      row_pos = (y == ht - 1) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Pixel driver: hold the offered pixel until taken, then pull the next
  // one from the queue unless this cycle is picked as a gap.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) filter_pixel(pix_ch.pixel);
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          pix_ch.valid <= 1'b1;
          pix_ch.pixel <= pixels_to_send.pop_front();
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls, forced low during the long hold-off.
  always @(posedge clk) begin
    if (hold_off) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long hold-off: once armed, wait for the first offered result, then
  // refuse results long enough for the block to back up into its input.
  initial begin : long_hold
    wait (hold_armed);
    @(posedge clk);
    while (!res_ch.valid) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic report_sample(input string why, input filt_sample_t want,
                               input filt_sample_t got);
    bad_samples++;
    if (bad_samples <= REPORT_LIMIT) begin
      $display("%0t %s: expected value %0d col %0d row %0d last %0b eof %0b",
               $realtime, why, want.value, want.column, want.row,
               want.last_of_run, want.end_of_frame);
      $display("      got value %0d col %0d row %0d last %0b eof %0b",
               got.value, got.column, got.row, got.last_of_run, got.end_of_frame);
    end
  endtask

  // Result monitor: match each transaction against the oldest due sample.
  always @(posedge clk) begin : result_check
    filt_sample_t got;
    filt_sample_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.value        = res_ch.value;
      got.column       = res_ch.column;
      got.row          = res_ch.row;
      got.last_of_run  = res_ch.last_of_run;
      got.end_of_frame = res_ch.end_of_frame;
      if (samples_due.size() == 0) begin
        report_sample("unexpected result", '0, got);
      end else begin
        want = samples_due.pop_front();
        if (got.value !== want.value || got.column !== want.column ||
            got.row !== want.row || got.last_of_run !== want.last_of_run ||
            got.end_of_frame !== want.end_of_frame) begin
          report_sample("result mismatch", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers. Everything that touches the pixel queue or the idle
  // rates runs just after a falling edge, away from the clocked blocks.
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_IMAGE_WIDTH:  width_reg = val[WIDTH_REG_W-1:0];
      REG_IMAGE_HEIGHT: height_reg = val[HEIGHT_REG_W-1:0];
      REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4:
        kernel[idx - REG_COEF_0] = val[COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Mix of full-range, extreme and smoothing-sized taps.
  function automatic int random_tap();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 131071)) + COEF_MIN;
      1: return int'($urandom_range(0, 24576)) - 8192;
      2: return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
      default: return int'($urandom_range(0, 12000));
    endcase
  endfunction

  function automatic pix_t random_pixel();
    logic [PIX_W-1:0] r;
    r = PIX_W'($urandom);
    case ($urandom_range(0, 7))
      0: return PIX_HI;
      1: return PIX_LO;
      default: return r;
    endcase
  endfunction

  task automatic load_random_kernel();
    int i;
    for (i = 0; i < NUM_COEF; i++) begin
      write_reg(CFG_IDX_W'(REG_COEF_0 + i), random_tap());
    end
  endtask

  task automatic queue_random_pixels(input int n);
    @(negedge clk);
    repeat (n) pixels_to_send.push_back(random_pixel());
    pixels_queued += n;
  endtask

  // Wait until the block is drained and quiet, so registers may change.
  task automatic settle();
    while (pixels_to_send.size() != 0 || pix_ch.valid || samples_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    sender_idle_pct = send_pct;
    recv_stall_pct  = recv_pct;
  endtask

  // One whole frame of the given size with a random kernel and content.
  task automatic run_frame(input int wd, input int ht);
    write_reg(REG_IMAGE_WIDTH, wd);
    write_reg(REG_IMAGE_HEIGHT, ht);
    load_random_kernel();
    close_writes();
    queue_random_pixels(wd * ht);
    settle();
  endtask

  initial begin : stimulus
    int i;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    res_ch.ready = 1'b0;
    width_reg    = WIDTH_REG_W'(MAX_WIDTH);
    height_reg   = HEIGHT_REG_W'(RESET_HEIGHT);
    col_pos      = 0;
    row_pos      = 0;
    for (i = 0; i < NUM_COEF; i++) kernel[i] = '0;
    for (i = 0; i < TAPS; i++) recent_px[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frame: smallest legal size, extreme taps, rails on the
    // pixels so both passes clip both ways and the borders pass rails
    // through. A write to the spare index must change nothing.
    set_idling(24, 74);
    write_reg(REG_IMAGE_WIDTH, TAPS);
    write_reg(REG_IMAGE_HEIGHT, TAPS);
    write_reg(REG_COEF_0, COEF_MIN);
    write_reg(REG_COEF_1, 32768);
    write_reg(REG_COEF_2, COEF_MAX);
    write_reg(REG_COEF_3, -16384);
    write_reg(REG_COEF_4, COEF_MAX);
    write_reg(REG_SPARE, COEF_MIN);
    close_writes();
    for (i = 0; i < TAPS * TAPS; i++) begin
      case (i % 3)
        0: pixels_to_send.push_back(PIX_HI);
        1: pixels_to_send.push_back(PIX_LO);
        default: pixels_to_send.push_back(pix_t'(i - 12));
      endcase
    end
    settle();

    // Sizes below the minimum clamp up to TAPS x TAPS.
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, TAPS - 2);
    load_random_kernel();
    close_writes();
    queue_random_pixels(TAPS * TAPS);
    settle();

    // Fill every line slot across STORE_COLS columns so that later width
    // changes only ever read columns that hold data.
    write_reg(REG_IMAGE_WIDTH, STORE_COLS);
    write_reg(REG_IMAGE_HEIGHT, 7);
    load_random_kernel();
    close_writes();
    queue_random_pixels(STORE_COLS * 7);
    settle();

    // Widen mid-row in the middle of a frame: the vertical sums of the
    // new columns read line entries left over from the previous frame.
    write_reg(REG_IMAGE_WIDTH, 8);
    write_reg(REG_IMAGE_HEIGHT, 8);
    close_writes();
    queue_random_pixels(5 * 8 + 3);
    settle();
    write_reg(REG_IMAGE_WIDTH, STORE_COLS);
    close_writes();
    queue_random_pixels((STORE_COLS - 3) + 2 * STORE_COLS);
    settle();

    set_idling(74, 24);

    // Oversized registers clamp to the maximum; then rewrite the exact
    // maxima, shrink the width under the column counter (ends the row at
    // once) and later shrink the height under the row counter (ends the
    // frame on the current row).
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_IMAGE_HEIGHT, 8191);
    close_writes();
    queue_random_pixels(7);
    settle();
    write_reg(REG_IMAGE_WIDTH, MAX_WIDTH);
    write_reg(REG_IMAGE_HEIGHT, MAX_HEIGHT);
    close_writes();
    queue_random_pixels(8);
    settle();
    write_reg(REG_IMAGE_WIDTH, 9);
    close_writes();
    queue_random_pixels(1 + 5 * 9);
    settle();
    write_reg(REG_IMAGE_HEIGHT, TAPS);
    close_writes();
    queue_random_pixels(9);
    settle();

    // No idling at all, with one long result hold-off in a frame tall
    // enough that the block backs up into its input.
    set_idling(0, 0);
    hold_armed = 1'b1;
    run_frame(STORE_COLS, HOLD_ROWS);

    if (bad_samples == 0) begin
      $display("[separable_fir_image_filter] OK");
    end else begin
      $display("[separable_fir_image_filter] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #10_000_000;
    $display("[separable_fir_image_filter] ERROR");
    $finish;
  end

endmodule
